@@ rtl/core/assert_macros.svh @@
// assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/core/pp420_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pp420_pkg;

  // sample and register widths
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned SIZE_W   = 11;
  // wide enough for any clamped size up to 4096
  localparam int unsigned EXT_W    = 13;
  localparam int unsigned POS_W    = 10;
  localparam int unsigned CPOS_W   = 9;

  // configuration port
  localparam int unsigned CFG_AW   = 3;
  localparam int unsigned CFG_DW   = 32;

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = 11'd720;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 11'd576;

  // register index, taken from paddr bit 2
  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  // raster position of the pixel being accepted
  typedef struct packed {
    logic [EXT_W-1:0] row;
    logic [EXT_W-1:0] col;
    logic             last_row;
    logic             last_col;
  } pos_t;

endpackage

`default_nettype wire

@@ rtl/core/pp420_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

// packed pixel request channel
interface pp420_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] chroma_in;
  logic [7:0] luma_in;

  modport source (output valid, output chroma_in, output luma_in, input ready);
  modport sink   (input valid, input chroma_in, input luma_in, output ready);
endinterface

// planar result request channel
interface pp420_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma_out;
  logic [9:0] pixel_row;
  logic [9:0] pixel_col;
  logic       chroma_valid;
  logic [7:0] chroma_out;
  logic       chroma_is_v;
  logic [8:0] chroma_row;
  logic [8:0] chroma_col;
  logic       end_of_frame;

  modport source (output valid, output luma_out, output pixel_row, output pixel_col,
                  output chroma_valid, output chroma_out, output chroma_is_v,
                  output chroma_row, output chroma_col, output end_of_frame,
                  input ready);
  modport sink   (input valid, input luma_out, input pixel_row, input pixel_col,
                  input chroma_valid, input chroma_out, input chroma_is_v,
                  input chroma_row, input chroma_col, input end_of_frame,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/core/pp420_raster_cnt.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pp420_raster_cnt
  import pp420_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire logic [SIZE_W-1:0] frame_width,
  input  wire logic [SIZE_W-1:0] frame_height,
  output pos_t                   pos
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam logic [EXT_W-1:0] MAX_W_X = EXT_W'(MAX_WIDTH);
  localparam logic [EXT_W-1:0] MAX_H_X = EXT_W'(MAX_HEIGHT);

  // zero is taken as one, anything above the maximum as the maximum
  function automatic logic [EXT_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                  input logic [EXT_W-1:0]  maxv);
    logic [EXT_W-1:0] vx;
    vx = EXT_W'(v);
    if (vx == '0) begin
      clamp_size = EXT_W'(1);
    end else if (vx > maxv) begin
      clamp_size = maxv;
    end else begin
      clamp_size = vx;
    end
  endfunction

  logic [CW-1:0]    col_r, col_nxt;
  logic [RW-1:0]    row_r, row_nxt;
  logic [EXT_W-1:0] w_m1;
  logic [EXT_W-1:0] h_m1;

  // end-of-row and end-of-frame compare
  always_comb begin
    w_m1         = clamp_size(frame_width, MAX_W_X) - EXT_W'(1);
    h_m1         = clamp_size(frame_height, MAX_H_X) - EXT_W'(1);
    pos.row      = EXT_W'(row_r);
    pos.col      = EXT_W'(col_r);
    pos.last_col = (pos.col >= w_m1);
    pos.last_row = (pos.row >= h_m1);
  end

  // wrap at row and frame end
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (step) begin
      if (pos.last_col) begin
        col_nxt = '0;
        row_nxt = pos.last_row ? '0 : row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/pp420_line_store.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pp420_line_store
  import pp420_pkg::*;
#(
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     wr,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [DATA_W-1:0]        wdata,
  output logic [DATA_W-1:0]             rdata_r
);

  logic [DATA_W-1:0] mem [DEPTH];

  // one access per pixel, read data registered
  always_ff @(posedge clk) begin
    if (en) begin
      if (wr) begin
        mem[addr] <= wdata;
      end
      rdata_r <= mem[addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/pp420_out_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pp420_out_stage
  import pp420_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              s1_valid,
  input  pos_t                   s1_pos,
  input  wire logic [DATA_W-1:0] s1_chroma,
  input  wire logic [DATA_W-1:0] s1_luma,
  input  wire logic [DATA_W-1:0] stored,
  output logic                   s1_take,
  pp420_out_if.source            out_chan
);

  logic              valid_r, valid_nxt;
  logic              odd_row;
  logic              cvalid;
  logic [DATA_W:0]   sum;
  logic [DATA_W-1:0] cval;

  logic [DATA_W-1:0] luma_r;
  logic [POS_W-1:0]  prow_r, pcol_r;
  logic              cvalid_r, is_v_r, eof_r;
  logic [DATA_W-1:0] cout_r;
  logic [CPOS_W-1:0] crow_r, ccol_r;

  assign s1_take = !valid_r || out_chan.ready;

  // average with the stored even-row byte, rounding up
  always_comb begin
    odd_row = s1_pos.row[0];
    cvalid  = odd_row || s1_pos.last_row;
    sum     = {1'b0, stored} + {1'b0, s1_chroma} + (DATA_W+1)'(1);
    cval    = odd_row ? sum[DATA_W:1] : s1_chroma;
  end

  always_comb begin
    valid_nxt = valid_r;
    if (s1_take) begin
      valid_nxt = s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (s1_take && s1_valid) begin
      luma_r   <= s1_luma;
      prow_r   <= s1_pos.row[POS_W-1:0];
      pcol_r   <= s1_pos.col[POS_W-1:0];
      cvalid_r <= cvalid;
      cout_r   <= cvalid ? cval : '0;
      is_v_r   <= cvalid & s1_pos.col[0];
      crow_r   <= cvalid ? s1_pos.row[CPOS_W:1] : '0;
      ccol_r   <= cvalid ? s1_pos.col[CPOS_W:1] : '0;
      eof_r    <= s1_pos.last_row & s1_pos.last_col;
    end
  end

  assign out_chan.valid        = valid_r;
  assign out_chan.luma_out     = luma_r;
  assign out_chan.pixel_row    = prow_r;
  assign out_chan.pixel_col    = pcol_r;
  assign out_chan.chroma_valid = cvalid_r;
  assign out_chan.chroma_out   = cout_r;
  assign out_chan.chroma_is_v  = is_v_r;
  assign out_chan.chroma_row   = crow_r;
  assign out_chan.chroma_col   = ccol_r;
  assign out_chan.end_of_frame = eof_r;

endmodule

`default_nettype wire

@@ rtl/core/packed_422_to_planar_420_unit.sv @@
// Packed 4:2:2 to planar 4:2:0 converter. One chroma/luma pair is taken per
// clock unless the output stalls, a sustained rate set by the single-port line
// store (MAX_WIDTH bytes) that takes either one write (even rows) or one read
// (odd rows) per pixel. Every pair gives exactly one result, via the input and
// result registers: the luma byte with its row and column, plus a 4:2:0 chroma
// sample on odd rows (rounded-up average with the byte stored from the even
// row above) and on the last row of an odd-height frame (raw). The path from
// out ready to in ready is combinational. The line store is not cleared after
// reset; an odd row must follow its even row. Frame width and height sit at
// byte addresses 0 and 4 and should be written while idle.
`timescale 1ns / 1ps
`default_nettype none

module packed_422_to_planar_420_unit
  import pp420_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  pp420_in_if.sink               in_chan,
  pp420_out_if.source            out_chan,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0]      cfg_prdata,
  output logic                   cfg_pready
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);

  logic [SIZE_W-1:0] width_r, height_r;
  reg_idx_t          reg_sel;
  logic              cfg_wr;

  pos_t              pos;
  logic              in_accept;
  logic              s1_take;
  logic              s1_valid_r, s1_valid_nxt;
  pos_t              s1_pos_r;
  logic [DATA_W-1:0] s1_chroma_r, s1_luma_r;
  logic [DATA_W-1:0] stored;

  // configuration registers
  assign reg_sel    = reg_idx_t'(cfg_paddr[2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_comb begin
    unique case (reg_sel)
      REG_WIDTH:  cfg_prdata = CFG_DW'(width_r);
      REG_HEIGHT: cfg_prdata = CFG_DW'(height_r);
      default:    cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_WIDTH:  width_r  <= cfg_pwdata[SIZE_W-1:0];
        REG_HEIGHT: height_r <= cfg_pwdata[SIZE_W-1:0];
        default:    ;
      endcase
    end
  end

  // input handshake
  assign in_chan.ready = !s1_valid_r || s1_take;
  assign in_accept     = in_chan.valid && in_chan.ready;

  pp420_raster_cnt #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_raster_cnt (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (in_accept),
    .frame_width  (width_r),
    .frame_height (height_r),
    .pos          (pos)
  );

  // even rows write, odd rows read
  pp420_line_store #(
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .en      (in_accept),
    .wr      (!pos.row[0]),
    .addr    (pos.col[CW-1:0]),
    .wdata   (in_chan.chroma_in),
    .rdata_r (stored)
  );

  // input register, aligned with the line store read
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_take) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_pos_r    <= pos;
      s1_chroma_r <= in_chan.chroma_in;
      s1_luma_r   <= in_chan.luma_in;
    end
  end

  pp420_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid_r),
    .s1_pos    (s1_pos_r),
    .s1_chroma (s1_chroma_r),
    .s1_luma   (s1_luma_r),
    .stored    (stored),
    .s1_take   (s1_take),
    .out_chan  (out_chan)
  );

endmodule

`default_nettype wire

@@ rtl/core/pp420_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module pp420_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] luma_out,
  input wire logic [9:0] pixel_row,
  input wire logic [9:0] pixel_col,
  input wire logic       chroma_valid,
  input wire logic [7:0] chroma_out,
  input wire logic       chroma_is_v,
  input wire logic [8:0] chroma_row,
  input wire logic [8:0] chroma_col,
  input wire logic       end_of_frame
);

  // a stalled result holds
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(luma_out) && $stable(pixel_col) && $stable(chroma_out))

  // the last pixel of a frame always carries chroma
  `ASSERT_IMPLY(a_eof_chroma, clk, rst_n, out_valid && end_of_frame, chroma_valid)

  // odd rows always carry chroma
  `ASSERT_IMPLY(a_odd_chroma, clk, rst_n, out_valid && pixel_row[0], chroma_valid)

  // chroma position follows the pixel position
  `ASSERT_IMPLY(a_chroma_pos, clk, rst_n, out_valid && chroma_valid, (chroma_is_v == pixel_col[0]) && (chroma_row == pixel_row[9:1]) && (chroma_col == pixel_col[9:1]))

  // no chroma means zeroed chroma fields
  `ASSERT_IMPLY(a_chroma_zero, clk, rst_n, out_valid && !chroma_valid, (chroma_out == 8'd0) && !chroma_is_v && (chroma_row == 9'd0) && (chroma_col == 9'd0))

endmodule

bind packed_422_to_planar_420_unit pp420_checker u_pp420_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .luma_out     (out_chan.luma_out),
  .pixel_row    (out_chan.pixel_row),
  .pixel_col    (out_chan.pixel_col),
  .chroma_valid (out_chan.chroma_valid),
  .chroma_out   (out_chan.chroma_out),
  .chroma_is_v  (out_chan.chroma_is_v),
  .chroma_row   (out_chan.chroma_row),
  .chroma_col   (out_chan.chroma_col),
  .end_of_frame (out_chan.end_of_frame)
);

`default_nettype wire

@@ tb/sv/packed_422_to_planar_420_unit_tb.sv @@
`timescale 1ns / 1ps

module packed_422_to_planar_420_unit_tb;
  import pp420_pkg::*;

  localparam int unsigned LINE_MAX     = 1024;
  localparam int unsigned RANDOM_ITEMS = 250;
  localparam int unsigned TALL_ROWS    = 300;
  localparam int unsigned LONG_STALL   = 300;
  localparam int unsigned PIPE_SLACK   = 10;

  // one planar output pixel as predicted
  typedef struct packed {
    logic [7:0] luma;
    logic [9:0] row;
    logic [9:0] col;
    logic       cvalid;
    logic [7:0] cval;
    logic       is_v;
    logic [8:0] crow;
    logic [8:0] ccol;
    logic       eof;
  } planar_pixel_t;

  logic clk;
  logic rst_n;

  pp420_in_if  in_chan ();
  pp420_out_if out_chan ();

  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  packed_422_to_planar_420_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .out_chan   (out_chan),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // raster predictor state
  logic [SIZE_W-1:0] width_reg;
  logic [SIZE_W-1:0] height_reg;
  int unsigned       row_cnt;
  int unsigned       col_cnt;
  logic [7:0]        line_store [0:LINE_MAX-1];

  planar_pixel_t planar_pending_q [$];

  // run statistics
  int unsigned error_count;
  int unsigned pixels_sent;
  int unsigned pixels_checked;
  int unsigned chroma_averaged;
  int unsigned chroma_raw;
  int unsigned frames_ended;
  int unsigned cfg_writes;

  // sender and receiver pacing
  bit          steady_send;
  int unsigned stall_token;
  int unsigned stall_seen;
  int unsigned stall_left;
  int unsigned ready_run;
  bit          ready_level;

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int unsigned eff_size(input logic [SIZE_W-1:0] v);
    if (v == 0) return 1;
    if (v > LINE_MAX) return LINE_MAX;
    return v;
  endfunction

  // next planar pixel from one packed pair, advancing the raster
  function automatic planar_pixel_t predict_planar(input logic [7:0] c, input logic [7:0] y);
    int unsigned   w;
    int unsigned   h;
    logic          last_c;
    logic          last_r;
    logic [8:0]    sum;
    planar_pixel_t p;
    w = eff_size(width_reg);
    h = eff_size(height_reg);
    last_c = (col_cnt >= w - 1);
    last_r = (row_cnt >= h - 1);
    p = '0;
    p.luma = y;
    p.row = row_cnt[9:0];
    p.col = col_cnt[9:0];
    if (row_cnt[0]) begin
      sum = line_store[col_cnt] + c + 9'd1;
      p.cval = sum[8:1];
      p.cvalid = 1'b1;
    end else begin
      line_store[col_cnt] = c;
      if (last_r) begin
        p.cval = c;
        p.cvalid = 1'b1;
      end
    end
    if (p.cvalid) begin
      p.is_v = col_cnt[0];
      p.crow = row_cnt[9:1];
      p.ccol = col_cnt[9:1];
    end
    p.eof = last_c && last_r;
    if (last_c) begin
      col_cnt = 0;
      row_cnt = last_r ? 0 : row_cnt + 1;
    end else begin
      col_cnt = col_cnt + 1;
    end
    return p;
  endfunction

  task automatic report_error(input string msg);
    error_count++;
    $display("mismatch: %s", msg);
  endtask

  task automatic check_field(input string name, input int unsigned got, input int unsigned want);
    if (got != want)
      report_error($sformatf("pixel %0d %s got %0d want %0d", pixels_checked, name, got, want));
  endtask

  function automatic logic [7:0] rand_sample();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 8'd0;
    if (r < 20) return 8'd255;
    return 8'($urandom);
  endfunction

  function automatic int unsigned sender_gap();
    int unsigned r;
    if (steady_send) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // offer one packed pair and wait for the request to be taken
  task automatic send_pixel(input logic [7:0] c, input logic [7:0] y);
    int unsigned gap;
    planar_pending_q.push_back(predict_planar(c, y));
    in_chan.valid     <= 1'b1;
    in_chan.chroma_in <= c;
    in_chan.luma_in   <= y;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    pixels_sent++;
    gap = sender_gap();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random_pixel();
    send_pixel(rand_sample(), rand_sample());
  endtask

  // stop offering and wait for every pending result
  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    while (planar_pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // resizing is only safe on an even row, so the next odd row finds its line written
  task automatic cfg_write(input reg_idx_t idx, input logic [CFG_DW-1:0] data);
    while (row_cnt[0]) send_random_pixel();
    wait_drained();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx == REG_WIDTH) width_reg = data[SIZE_W-1:0];
    else height_reg = data[SIZE_W-1:0];
    cfg_writes++;
  endtask

  // size word with noise in the unused upper bits
  function automatic logic [CFG_DW-1:0] size_word(input int unsigned v);
    return ($urandom & ~32'h7FF) | (v & 32'h7FF);
  endfunction

  task automatic pad_to_frame_start();
    while (row_cnt != 0 || col_cnt != 0) send_random_pixel();
  endtask

  // compare one taken result with the oldest prediction
  task automatic check_result();
    planar_pixel_t want;
    if (planar_pending_q.size() == 0) begin
      report_error("result with nothing pending");
      return;
    end
    want = planar_pending_q.pop_front();
    check_field("luma_out", out_chan.luma_out, want.luma);
    check_field("pixel_row", out_chan.pixel_row, want.row);
    check_field("pixel_col", out_chan.pixel_col, want.col);
    check_field("chroma_valid", out_chan.chroma_valid, want.cvalid);
    check_field("chroma_out", out_chan.chroma_out, want.cval);
    check_field("chroma_is_v", out_chan.chroma_is_v, want.is_v);
    check_field("chroma_row", out_chan.chroma_row, want.crow);
    check_field("chroma_col", out_chan.chroma_col, want.ccol);
    check_field("end_of_frame", out_chan.end_of_frame, want.eof);
    if (want.cvalid && want.row[0]) chroma_averaged++;
    else if (want.cvalid) chroma_raw++;
    if (want.eof) frames_ended++;
    pixels_checked++;
  endtask

  // result side: check taken results, pace ready, honor long hold-off requests
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) check_result();
    if (stall_token != stall_seen) begin
      stall_seen = stall_token;
      stall_left = LONG_STALL;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_chan.ready <= 1'b0;
    end else begin
      if (ready_run == 0) begin
        case ($urandom_range(0, 19))
          0: begin
            ready_level = 1'b0;
            ready_run = $urandom_range(15, 60);
          end
          1, 2, 3, 4: begin
            ready_level = 1'b0;
            ready_run = $urandom_range(1, 3);
          end
          default: begin
            ready_level = 1'b1;
            ready_run = $urandom_range(1, 30);
          end
        endcase
      end
      ready_run--;
      out_chan.ready <= ready_level;
    end
  end

  // reset sizes, luma-only pixels, averaging with rounding, raw last row,
  // zero sizes, and a shrink that wraps the column counter mid-frame
  task automatic test_directed_cases();
    send_pixel(8'd17, 8'd0);
    send_pixel(8'd200, 8'd255);
    send_pixel(8'd99, 8'd1);
    cfg_write(REG_WIDTH, 32'd4);
    cfg_write(REG_HEIGHT, 32'd3);
    send_pixel(8'd254, 8'd254);
    send_pixel(8'd255, 8'd10);
    send_pixel(8'd255, 8'd20);
    send_pixel(8'd0, 8'd30);
    send_pixel(8'd1, 8'd40);
    send_pixel(8'd0, 8'd255);
    send_pixel(8'd128, 8'd0);
    send_pixel(8'd255, 8'd128);
    send_pixel(8'd7, 8'd127);
    cfg_write(REG_WIDTH, 32'd0);
    cfg_write(REG_HEIGHT, 32'd0);
    repeat (3) send_random_pixel();
    cfg_write(REG_WIDTH, 32'd8);
    cfg_write(REG_HEIGHT, 32'd4);
    send_pixel(8'd0, 8'd1);
    send_pixel(8'd255, 8'd2);
    send_pixel(8'd0, 8'd3);
    send_pixel(8'd255, 8'd4);
    send_pixel(8'd3, 8'd5);
    send_pixel(8'd4, 8'd6);
    cfg_write(REG_WIDTH, 32'd3);
    send_pixel(8'd255, 8'd255);
    send_pixel(8'd0, 8'd0);
    send_pixel(8'd255, 8'd99);
  endtask

  // widest row, the top of a frame taller than the maximum, and clamping of
  // sizes above the maximum
  task automatic test_size_extremes();
    pad_to_frame_start();
    cfg_write(REG_WIDTH, size_word(11'h7FF));
    cfg_write(REG_HEIGHT, size_word(1));
    repeat (LINE_MAX) send_random_pixel();
    cfg_write(REG_WIDTH, size_word(1));
    cfg_write(REG_HEIGHT, size_word(LINE_MAX + 1));
    repeat (TALL_ROWS) send_random_pixel();
    cfg_write(REG_WIDTH, size_word(LINE_MAX));
    cfg_write(REG_HEIGHT, size_word(LINE_MAX));
    repeat (20) send_random_pixel();
  endtask

  // long result hold-off while requests keep coming, then a full drain
  task automatic test_backpressure();
    cfg_write(REG_WIDTH, 32'd16);
    cfg_write(REG_HEIGHT, 32'd4);
    stall_token <= stall_token + 1;
    steady_send = 1'b1;
    repeat (80) send_random_pixel();
    steady_send = 1'b0;
    wait_drained();
    repeat (40) send_random_pixel();
  endtask

  // many small frames with sizes changed between and inside frames
  task automatic test_random_frames();
    int unsigned sent;
    int unsigned n;
    int unsigned r;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        r = $urandom_range(0, 99);
        if (r < 8) cfg_write(REG_WIDTH, size_word(0));
        else if (r < 80) cfg_write(REG_WIDTH, size_word($urandom_range(1, 12)));
        else cfg_write(REG_WIDTH, size_word($urandom_range(13, 40)));
      end
      if ($urandom_range(0, 99) < 80) cfg_write(REG_HEIGHT, size_word($urandom_range(0, 8)));
      n = $urandom_range(1, 3 * eff_size(width_reg) * eff_size(height_reg));
      if (n > 300) n = 300;
      steady_send = ($urandom_range(0, 3) == 0);
      repeat (n) send_random_pixel();
      steady_send = 1'b0;
      sent += n;
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.chroma_in = '0;
    in_chan.luma_in = '0;
    out_chan.ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    width_reg = WIDTH_RESET;
    height_reg = HEIGHT_RESET;
    row_cnt = 0;
    col_cnt = 0;
    steady_send = 1'b0;
    stall_token = 0;
    stall_seen = 0;
    stall_left = 0;
    ready_run = 0;
    ready_level = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_size_extremes();
    test_backpressure();
    test_random_frames();

    wait_drained();
    repeat (PIPE_SLACK) @(posedge clk);
    if (planar_pending_q.size() != 0)
      report_error($sformatf("%0d results never arrived", planar_pending_q.size()));
    $display("run covered %0d pixels and %0d frame ends across %0d size writes",
             pixels_checked, frames_ended, cfg_writes);
    $display("chroma samples: %0d averaged, %0d raw; %0d errors",
             chroma_averaged, chroma_raw, error_count);
    if (error_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  // watchdog
  initial begin
    #60_000_000;
    $display("watchdog expired with %0d results pending", planar_pending_q.size());
    $display("status: fail");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/pp420_pkg.sv
rtl/core/pp420_if.sv
rtl/core/pp420_raster_cnt.sv
rtl/core/pp420_line_store.sv
rtl/core/pp420_out_stage.sv
rtl/core/packed_422_to_planar_420_unit.sv
rtl/core/pp420_checker.sv
tb/sv/packed_422_to_planar_420_unit_tb.sv
